// ===== hw/rtl/quoted_key_value_tokenizer_unit_assert.svh =====
// Assertion macros shared by the tokenizer RTL. They expand to nothing
// when SYNTHESIS is defined.
`ifndef QUOTED_KEY_VALUE_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_KEY_VALUE_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QKVT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define QKVT_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define QKVT_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define QKVT_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ===== hw/rtl/qkvt_pkg.sv =====
package qkvt_pkg;

  // One input request: a buffer byte, or the end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } qkvt_in_t;

  // One result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       option_done;
    logic [2:0] status;
  } qkvt_out_t;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_SKIP   = 8'b0000_0001,
    PH_KEY    = 8'b0000_0010,
    PH_EQ     = 8'b0000_0100,
    PH_PLAIN  = 8'b0000_1000,
    PH_QUOTED = 8'b0001_0000,
    PH_ESC    = 8'b0010_0000,
    PH_CLOSED = 8'b0100_0000,
    PH_HOLD   = 8'b1000_0000
  } qkvt_phase_t;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  localparam logic [2:0] ST_BUSY  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_END   = 3'd2;
  localparam logic [2:0] ST_NOOPT = 3'd3;
  localparam logic [2:0] ST_ERROR = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_key_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER) || (c == CH_COLON);
  endfunction

endpackage

// ===== hw/rtl/qkvt_step.sv =====
// Decides one request: next parser phase and the result it produces.
module qkvt_step (
  input  qkvt_pkg::qkvt_phase_t phase,
  input  qkvt_pkg::qkvt_in_t    req,
  output qkvt_pkg::qkvt_phase_t phase_nxt,
  output qkvt_pkg::qkvt_out_t   res
);
  import qkvt_pkg::*;

  logic [7:0] c;
  logic       eob;
  logic       ws;
  logic       key_ch;

  assign c      = req.data_byte;
  assign eob    = req.end_of_buffer;
  assign ws     = is_ws(c);
  assign key_ch = is_key_char(c);

  always_comb begin
    phase_nxt       = phase;
    res.out_byte    = 8'd0;
    res.out_kind    = KIND_NONE;
    res.option_done = 1'b0;
    res.status      = ST_BUSY;
    unique case (phase)
      PH_SKIP: begin
        if (eob) begin
          res.status = ST_END;
        end else if (ws) begin
          phase_nxt = PH_SKIP;
        end else if (key_ch) begin
          res.out_byte = c;
          res.out_kind = KIND_KEY;
          phase_nxt    = PH_KEY;
        end else begin
          res.status = ST_NOOPT;
          phase_nxt  = PH_HOLD;
        end
      end
      PH_KEY: begin
        if (eob) begin
          res.status = ST_NOOPT;
          phase_nxt  = PH_SKIP;
        end else if (key_ch) begin
          res.out_byte = c;
          res.out_kind = KIND_KEY;
        end else if (c == CH_EQUAL) begin
          phase_nxt = PH_EQ;
        end else begin
          res.status = ST_NOOPT;
          phase_nxt  = PH_HOLD;
        end
      end
      PH_EQ: begin
        if (eob) begin
          res.status = ST_ERROR;
          phase_nxt  = PH_SKIP;
        end else if (ws) begin
          res.status = ST_ERROR;
          phase_nxt  = PH_HOLD;
        end else if (c == CH_QUOTE) begin
          phase_nxt = PH_QUOTED;
        end else begin
          res.out_byte = c;
          res.out_kind = KIND_VALUE;
          phase_nxt    = PH_PLAIN;
        end
      end
      PH_PLAIN: begin
        if (eob || ws) begin
          res.option_done = 1'b1;
          res.status      = ST_DONE;
          phase_nxt       = PH_SKIP;
        end else begin
          res.out_byte = c;
          res.out_kind = KIND_VALUE;
        end
      end
      PH_QUOTED: begin
        if (eob) begin
          res.status = ST_ERROR;
          phase_nxt  = PH_SKIP;
        end else if (c == CH_QUOTE) begin
          phase_nxt = PH_CLOSED;
        end else if (c == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          res.out_byte = c;
          res.out_kind = KIND_VALUE;
        end
      end
      PH_ESC: begin
        if (eob) begin
          res.status = ST_ERROR;
          phase_nxt  = PH_SKIP;
        end else begin
          res.out_byte = c;
          res.out_kind = KIND_VALUE;
          phase_nxt    = PH_QUOTED;
        end
      end
      PH_CLOSED: begin
        if (eob || ws) begin
          res.option_done = 1'b1;
          res.status      = ST_DONE;
          phase_nxt       = PH_SKIP;
        end else begin
          res.status = ST_ERROR;
          phase_nxt  = PH_HOLD;
        end
      end
      default: begin
        // Hold: wait for the end marker, then start over.
        if (eob) begin
          res.status = ST_END;
          phase_nxt  = PH_SKIP;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/quoted_key_value_tokenizer_unit.sv =====
// Streaming name=value option tokenizer. Each request carries one buffer byte
// or the end marker that stands for the terminating NUL, and every request
// yields exactly one result: the key or unescaped value byte it emits, its
// kind, an option-complete pulse and a status. The block sustains one request
// per clock cycle while out_ready is high. A request is held in the input
// register, and its result is loaded into the output register once that is
// free, raising out_valid; it stays there until out_ready takes it. When a
// result waits in the output register, the input register still holds one
// more request; in_ready drops only while both registers are full and
// out_ready is low. The rate is set by the parser phase register, which is
// read and rewritten in the same cycle for every request that moves from the
// input register to the output register.
`include "quoted_key_value_tokenizer_unit_assert.svh"
module quoted_key_value_tokenizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qkvt_pkg::qkvt_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qkvt_pkg::qkvt_out_t out_data
);
  import qkvt_pkg::*;

  // Input register stage.
  logic        s1_valid_r;
  qkvt_in_t    s1_data_r;

  // Output register stage.
  logic        out_valid_r;
  qkvt_out_t   out_data_r;

  // Parser phase, advanced once per request that reaches the output stage.
  qkvt_phase_t phase_r;
  qkvt_phase_t phase_nxt;
  qkvt_out_t   res;

  logic        out_free;
  logic        advance;

  // The output register can take a new result when it is empty or its
  // current result is being taken this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  // The input register takes a new request while its current one moves on,
  // so requests flow back to back as long as the output register can take a result.
  assign in_ready = !s1_valid_r || advance;

  qkvt_step u_step (
    .phase     (phase_r),
    .req       (s1_data_r),
    .phase_nxt (phase_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SKIP;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `QKVT_ASSERT_ALWAYS(a_reset_phase, clk,
    !rst_n |=> phase_r == PH_SKIP, "phase not reset")
  `QKVT_ASSERT(a_end_restarts, clk, rst_n,
    advance && s1_data_r.end_of_buffer |=> phase_r == PH_SKIP,
    "end item did not restart")
  `QKVT_ASSERT(a_done_status, clk, rst_n,
    out_valid_r |-> (out_data_r.option_done == (out_data_r.status == ST_DONE)),
    "done pulse and status disagree")
  `QKVT_ASSERT(a_none_zero, clk, rst_n,
    out_valid_r && out_data_r.out_kind == KIND_NONE |-> out_data_r.out_byte == 8'd0,
    "byte set with nothing emitted")
  `QKVT_ASSERT(a_emit_busy, clk, rst_n,
    out_valid_r && out_data_r.out_kind != KIND_NONE |-> out_data_r.status == ST_BUSY,
    "emitted byte with final status")

endmodule
